### hdl/tmf_pkg.sv
// ----------------------------------------------------------------------------
// tmf_pkg
// Types and constants shared by the temporal median filter modules.
// ----------------------------------------------------------------------------
package tmf_pkg;

    // Width of the window radius register.
    localparam int RADIUS_BITS = 4;

    // Control bits handed from one sort cell to the next.
    typedef struct packed {
        logic vld;    // the cell holds a sample
        logic shift;  // the cell moves its sample one place up on this insert
    } link_t;

endpackage

### hdl/temporal_median_filter.sv
// ----------------------------------------------------------------------------
// temporal_median_filter
// Each result is built from one window read per sample into the sort chain,
// then the last insert, then a load of the output register, which waits while
// the output is stalled. A new sample is taken only in the idle state, once every
// result of the previous one is loaded; an item with no result stays in idle.
// Synchronous active-low reset empties the sort chain, ends any series and
// sets the window radius to 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
module temporal_median_filter #(
    parameter  int MAX_RADIUS  = 14,
    parameter  int SAMPLE_BITS = 32,
    localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration: window radius.
    input  logic                              cfg_we,
    input  logic [tmf_pkg::RADIUS_BITS-1:0]   cfg_wdata,
    // Input samples.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [TDATA_BITS-1:0]             s_tdata,  // sample_value
    input  logic                              s_tlast,  // last_of_series
    input  logic [0:0]                        s_tuser,  // voxel_enabled
    // Filtered results.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [TDATA_BITS-1:0]             m_tdata,  // median_value
    output logic                              m_tlast   // last_result
);

    // Window depth, and the widths of the radius, frame count and sample counter.
    localparam int WIN  = 2 * MAX_RADIUS + 1;
    localparam int AW   = $clog2(WIN);
    localparam int CNTW = $clog2(WIN + 1);
    localparam int RW   = $clog2(MAX_RADIUS + 1);
    localparam int FW   = $clog2(MAX_RADIUS + 2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SORT,
        ST_EMIT
    } state_t;

    state_t                          state_reg, state_next;
    logic [tmf_pkg::RADIUS_BITS-1:0] cfg_reg, cfg_next;
    logic                            started_reg, started_next;
    logic [FW-1:0]                   fs_reg, fs_next;
    logic                            m_valid_reg, m_valid_next;
    logic [SAMPLE_BITS-1:0]          m_data_reg, m_data_next;
    logic                            m_last_reg, m_last_next;

    // Per-item job description, captured when the sample is accepted.
    logic [RW-1:0]   r_reg, r_next;
    logic [RW-1:0]   d_reg, d_next;
    logic [RW-1:0]   top_reg, top_next;
    logic            main_reg, main_next;
    logic            flush_reg, flush_next;
    logic            last_reg, last_next;
    logic            en_reg, en_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;

    logic            s_accept;
    logic            out_free;
    logic [RW-1:0]   r_eff;
    logic [FW-1:0]   fs_new;
    logic            emit_main;
    logic            want_flush;
    logic [CNTW-1:0] r_m1;
    logic [CNTW-1:0] fs_m1;
    logic [RW-1:0]   top_new;
    logic [CNTW-1:0] n_samples;
    logic [CNTW-1:0] base_idx;
    logic [CNTW:0]   diff_idx;
    logic [AW-1:0]   rd_idx;
    logic            rd_en;
    logic            rd_vld;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic            sort_clear;
    logic            emit_load;
    logic            job_last;

    tmf_pkg::link_t         cell_link [WIN];
    logic [SAMPLE_BITS-1:0] cell_val  [WIN];
    logic [SAMPLE_BITS-1:0] median;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // A radius register above the maximum acts as the maximum.
    assign r_eff = (int'(cfg_reg) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(cfg_reg);

    // Frame count after this sample; it saturates at MAX_RADIUS+1, which is enough
    // to know that every frame of the window is real.
    always_comb begin
        if (!started_reg) begin
            fs_new = FW'(1);
        end else if (int'(fs_reg) < MAX_RADIUS + 1) begin
            fs_new = FW'(fs_reg + 1'b1);
        end else begin
            fs_new = fs_reg;
        end
    end

    // The centered median is due once r frames past the center have arrived.
    // The final sample also flushes the frames still owed, from the oldest one
    // (r-1 frames back, or the first frame of a short series) down to itself.
    assign emit_main  = CNTW'(fs_new) > CNTW'(r_eff);
    assign want_flush = s_tlast && (r_eff != '0);
    assign r_m1       = CNTW'(r_eff) - 1'b1;
    assign fs_m1      = CNTW'(fs_new) - 1'b1;
    assign top_new    = (r_m1 < fs_m1) ? RW'(r_m1) : RW'(fs_m1);

    // For offset d the window spans taps d+r down to d-r; taps below zero
    // replicate the newest sample.
    assign n_samples = CNTW'({r_reg, 1'b1});
    assign base_idx  = CNTW'(d_reg) + CNTW'(r_reg);
    assign diff_idx  = {1'b0, base_idx} - {1'b0, cnt_reg};
    assign rd_idx    = diff_idx[CNTW] ? '0 : diff_idx[AW-1:0];
    assign rd_en     = (state_reg == ST_SORT) && (cnt_reg != n_samples);

    // The chain is emptied while the first sample of a job is being read.
    assign sort_clear = (state_reg == ST_SORT) && (cnt_reg == '0);
    assign emit_load  = (state_reg == ST_EMIT) && out_free;
    assign job_last   = main_reg ? (last_reg && (r_reg == '0)) : (d_reg == '0);
    assign median     = cell_val[AW'(r_reg)];

    always_comb begin
        state_next   = state_reg;
        cfg_next     = cfg_reg;
        started_next = started_reg;
        fs_next      = fs_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        r_next       = r_reg;
        d_next       = d_reg;
        top_next     = top_reg;
        main_next    = main_reg;
        flush_next   = flush_reg;
        last_next    = last_reg;
        en_next      = en_reg;
        cnt_next     = cnt_reg;

        if (cfg_we) begin
            cfg_next = cfg_wdata;
        end

        // The output register empties on its own handshake unless reloaded below.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    started_next = !s_tlast;
                    fs_next      = s_tlast ? '0 : fs_new;
                    r_next       = r_eff;
                    top_next     = top_new;
                    flush_next   = want_flush;
                    last_next    = s_tlast;
                    en_next      = s_tuser[0];
                    cnt_next     = '0;
                    if (emit_main) begin
                        main_next  = 1'b1;
                        d_next     = r_eff;
                        state_next = ST_SORT;
                    end else if (want_flush) begin
                        main_next  = 1'b0;
                        d_next     = top_new;
                        state_next = ST_SORT;
                    end
                end
            end
            ST_SORT: begin
                if (cnt_reg != n_samples) begin
                    cnt_next = CNTW'(cnt_reg + 1'b1);
                end else begin
                    // The last sample enters the chain in this cycle.
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = en_reg ? median : '0;
                    m_last_next  = job_last;
                    cnt_next     = '0;
                    if (main_reg && flush_reg) begin
                        main_next  = 1'b0;
                        d_next     = top_reg;
                        state_next = ST_SORT;
                    end else if (!main_reg && (d_reg != '0)) begin
                        d_next     = d_reg - 1'b1;
                        state_next = ST_SORT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cfg_reg     <= tmf_pkg::RADIUS_BITS'(1);
            started_reg <= 1'b0;
            fs_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cfg_reg     <= cfg_next;
            started_reg <= started_next;
            fs_reg      <= fs_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        r_reg      <= r_next;
        d_reg      <= d_next;
        top_reg    <= top_next;
        main_reg   <= main_next;
        flush_reg  <= flush_next;
        last_reg   <= last_next;
        en_reg     <= en_next;
        cnt_reg    <= cnt_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_BITS'(m_data_reg);
    assign m_tlast  = m_last_reg;

    // The first sample of a series fills the whole window.
    tmf_window #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DEPTH       (WIN)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (s_accept),
        .fill    (!started_reg),
        .wr_data (s_tdata[SAMPLE_BITS-1:0]),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx),
        .rd_vld  (rd_vld),
        .rd_data (rd_data)
    );

    // Sorted chain: every read sample is inserted as it arrives, and after the
    // last insert the cell at position r holds the median.
    for (genvar k = 0; k < WIN; k++) begin : g_cell
        tmf_pkg::link_t         prev_link;
        logic [SAMPLE_BITS-1:0] prev_data;

        if (k == 0) begin : g_head
            assign prev_link = '{vld: 1'b0, shift: 1'b0};
            assign prev_data = '0;
        end else begin : g_body
            assign prev_link = cell_link[k-1];
            assign prev_data = cell_val[k-1];
        end

        tmf_sort_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .clear     (sort_clear),
            .insert    (rd_vld),
            .ins_data  (rd_data),
            .prev_link (prev_link),
            .prev_data (prev_data),
            .cell_link (cell_link[k]),
            .cell_data (cell_val[k])
        );
    end

    // The first two cells stay in ascending order, with no gap below a filled second cell.
    a_chain_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_link[1].vld |-> cell_link[0].vld && ($signed(cell_val[0]) <= $signed(cell_val[1])))
        else $error("sort chain out of order");

    // Window reads only feed the chain during a sort job.
    a_insert_in_sort: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld |-> state_reg == ST_SORT)
        else $error("insert outside of a sort job");

    // The sample counter never passes the window length.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SORT |-> cnt_reg <= n_samples)
        else $error("sample counter past window length");

    // Frame offsets never exceed the radius of the running job.
    a_offset_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> d_reg <= r_reg)
        else $error("frame offset beyond radius");

    // A masked voxel always yields zero.
    a_mask_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_load && !en_reg |=> m_tdata[SAMPLE_BITS-1:0] == '0)
        else $error("masked result not zero");

endmodule

### hdl/tmf_sort_cell.sv
// ----------------------------------------------------------------------------
// tmf_sort_cell
// One place of the sorted sample chain; inserts keep the chain in ascending order.
// ----------------------------------------------------------------------------
module tmf_sort_cell #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   clear,
    input  logic                   insert,
    input  logic [SAMPLE_BITS-1:0] ins_data,
    input  tmf_pkg::link_t         prev_link,
    input  logic [SAMPLE_BITS-1:0] prev_data,
    output tmf_pkg::link_t         cell_link,
    output logic [SAMPLE_BITS-1:0] cell_data
);

    logic                   vld_reg;
    logic                   vld_next;
    logic [SAMPLE_BITS-1:0] data_reg;
    logic [SAMPLE_BITS-1:0] data_next;
    logic                   below;

    // An empty cell acts as plus infinity.
    assign below = !vld_reg || ($signed(ins_data) < $signed(data_reg));

    always_comb begin
        vld_next  = vld_reg;
        data_next = data_reg;
        if (clear) begin
            vld_next = 1'b0;
        end else if (insert && below) begin
            if (prev_link.shift) begin
                vld_next  = prev_link.vld;
                data_next = prev_data;
            end else begin
                vld_next  = 1'b1;
                data_next = ins_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        data_reg <= data_next;
    end

    assign cell_link.vld   = vld_reg;
    assign cell_link.shift = below;
    assign cell_data       = data_reg;

endmodule

### hdl/tmf_window.sv
// ----------------------------------------------------------------------------
// tmf_window
// Shift line of recent samples, newest first, with one registered read port.
// ----------------------------------------------------------------------------
module tmf_window #(
    parameter int SAMPLE_BITS = 32,
    parameter int DEPTH       = 29
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     wr_en,
    input  logic                     fill,
    input  logic [SAMPLE_BITS-1:0]   wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_idx,
    output logic                     rd_vld,
    output logic [SAMPLE_BITS-1:0]   rd_data
);

    logic [SAMPLE_BITS-1:0] tap_reg [DEPTH];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   rd_vld_reg;

    // A fill replicates the first sample of a series into every tap.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tap_reg[0] <= wr_data;
            for (int k = 1; k < DEPTH; k++) begin
                tap_reg[k] <= fill ? wr_data : tap_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= rd_en;
        end
        if (rd_en) begin
            rd_data_reg <= tap_reg[rd_idx];
        end
    end

    assign rd_vld  = rd_vld_reg;
    assign rd_data = rd_data_reg;

endmodule
